// ===== hw/rtl/rqy_pkg.sv =====
// Package for the RGB quad to YCbCr 4:2:0 converter.
// Holds the stage map, fixed-point coefficients, the pipeline control struct
// and the shared 2/3 scale-and-clamp function. No dependencies.
`default_nettype none

package rqy_pkg;

  // Pipeline stage map
  localparam int NUM_STAGES = 5;
  localparam int STG_PROD   = 0;  // luma partial products
  localparam int STG_LUMA   = 1;  // 12-bit luma
  localparam int STG_DIFF   = 2;  // chroma difference products
  localparam int STG_SCALE  = 3;  // 2/3 scale and clamp per pixel
  localparam int STG_OUT    = 4;  // chroma average and output offset

  // 12-bit fixed-point coefficients
  localparam logic [11:0] COEF_YR = 12'd1224;
  localparam logic [11:0] COEF_YG = 12'd2404;
  localparam logic [11:0] COEF_YB = 12'd466;
  localparam logic [11:0] COEF_U  = 12'd2314;
  localparam logic [11:0] COEF_V  = 12'd2920;

  localparam logic [3:0]         HALF_LSB    = 4'd8;
  localparam logic signed [10:0] CHROMA_BIAS = 11'sd127;
  localparam logic [7:0]         OUT_OFFSET  = 8'd128;

  // floor(n/3) == (n * RECIP3) >> RECIP3_SHIFT for every n below 1024 used here
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

  // One load enable per pipeline stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } rqy_pipe_ctl_t;

  // Scale by 2/3 (truncating toward zero) and clamp to 0..255.
  // Inputs stay below 310, so only the low clamp can trigger.
  function automatic logic [7:0] scale_clamp(input logic signed [10:0] x);
    logic [9:0]  n;
    logic [19:0] p;
    n = {x[8:0], 1'b0};
    p = n * RECIP3;
    scale_clamp = (x > 11'sd0) ? p[RECIP3_SHIFT+7:RECIP3_SHIFT] : 8'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rqy_ctrl.sv =====
// Pipeline control for the RGB quad converter: valid bits and stage loads.
// Depends on rqy_pkg for the stage count and control struct.
`default_nettype none

module rqy_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rqy_pkg::rqy_pipe_ctl_t     ctl
);

  logic [rqy_pkg::NUM_STAGES-1:0] valid_r;
  logic [rqy_pkg::NUM_STAGES-1:0] valid_nxt;
  logic [rqy_pkg::NUM_STAGES-1:0] rdy;

  // Ready ripples back: a stage may load when empty or when its successor loads
  always_comb begin
    rdy[rqy_pkg::NUM_STAGES-1] = !valid_r[rqy_pkg::NUM_STAGES-1] || out_ready;
    for (int k = rqy_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  // Advance valid bits with the data, hold them where stalled
  always_comb begin
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < rqy_pkg::NUM_STAGES; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[rqy_pkg::NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rqy_pixel.sv =====
// Per-pixel datapath: luma, chroma differences and 2/3 scale, four stages.
// Depends on rqy_pkg for coefficients, stage map and scale_clamp.
`default_nettype none

module rqy_pixel (
  input  wire logic               clk,
  input  wire rqy_pkg::rqy_pipe_ctl_t ctl,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output logic [7:0]              luma,
  output logic [7:0]              cb,
  output logic [7:0]              cr
);

  logic [11:0] r12, g12, b12;

  logic [23:0] prod_r_r, prod_g_r, prod_b_r;
  logic [7:0]  red_p_r, blue_p_r;

  logic [24:0] lsum;
  logic [11:0] y12_r;
  logic [7:0]  red_l_r, blue_l_r;

  logic signed [12:0] diff_u, diff_v;
  logic signed [25:0] pu_nxt, pv_nxt;
  logic signed [25:0] pu_r, pv_r;
  logic [7:0]         y8_r;

  logic signed [10:0] xu, xv, xy;
  logic [7:0]         luma_r, cb_r, cr_r;

  // Widen to 12-bit fixed point with a half-LSB offset
  assign r12 = {red,   rqy_pkg::HALF_LSB};
  assign g12 = {green, rqy_pkg::HALF_LSB};
  assign b12 = {blue,  rqy_pkg::HALF_LSB};

  // Stage: luma partial products
  always_ff @(posedge clk) begin
    if (ctl.load[rqy_pkg::STG_PROD]) begin
      prod_r_r <= r12 * rqy_pkg::COEF_YR;
      prod_g_r <= g12 * rqy_pkg::COEF_YG;
      prod_b_r <= b12 * rqy_pkg::COEF_YB;
      red_p_r  <= red;
      blue_p_r <= blue;
    end
  end

  // Stage: sum and drop 12 fraction bits (sum stays below 2^24)
  assign lsum = {1'b0, prod_r_r} + {1'b0, prod_g_r} + {1'b0, prod_b_r};

  always_ff @(posedge clk) begin
    if (ctl.load[rqy_pkg::STG_LUMA]) begin
      y12_r    <= lsum[23:12];
      red_l_r  <= red_p_r;
      blue_l_r <= blue_p_r;
    end
  end

  // Stage: color minus luma, times chroma coefficient
  assign diff_u = $signed({1'b0, blue_l_r, rqy_pkg::HALF_LSB}) - $signed({1'b0, y12_r});
  assign diff_v = $signed({1'b0, red_l_r,  rqy_pkg::HALF_LSB}) - $signed({1'b0, y12_r});
  assign pu_nxt = 26'(diff_u) * $signed({14'd0, rqy_pkg::COEF_U});
  assign pv_nxt = 26'(diff_v) * $signed({14'd0, rqy_pkg::COEF_V});

  always_ff @(posedge clk) begin
    if (ctl.load[rqy_pkg::STG_DIFF]) begin
      pu_r <= pu_nxt;
      pv_r <= pv_nxt;
      y8_r <= y12_r[11:4];
    end
  end

  // Stage: floor-shift by 16, add chroma bias, scale by 2/3 and clamp
  assign xu = $signed({pu_r[25], pu_r[25:16]}) + rqy_pkg::CHROMA_BIAS;
  assign xv = $signed({pv_r[25], pv_r[25:16]}) + rqy_pkg::CHROMA_BIAS;
  assign xy = $signed({3'b000, y8_r});

  always_ff @(posedge clk) begin
    if (ctl.load[rqy_pkg::STG_SCALE]) begin
      luma_r <= rqy_pkg::scale_clamp(xy);
      cb_r   <= rqy_pkg::scale_clamp(xu);
      cr_r   <= rqy_pkg::scale_clamp(xv);
    end
  end

  assign luma = luma_r;
  assign cb   = cb_r;
  assign cr   = cr_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_quad_to_ycbcr420_unit.sv =====
// Beats pass the product, luma, difference, scale and output stages in order.
// Throughput: one 2x2 RGB quad per cycle while out_ready is high; a stage
// holds a beat while the next is full and stalled: nothing drops or repeats.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only.
// Depends on rqy_pkg, rqy_ctrl and rqy_pixel.
`default_nettype none

module rgb_quad_to_ycbcr420_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_red_top_left,
  input  wire logic [7:0]        in_green_top_left,
  input  wire logic [7:0]        in_blue_top_left,
  input  wire logic [7:0]        in_red_top_right,
  input  wire logic [7:0]        in_green_top_right,
  input  wire logic [7:0]        in_blue_top_right,
  input  wire logic [7:0]        in_red_bottom_left,
  input  wire logic [7:0]        in_green_bottom_left,
  input  wire logic [7:0]        in_blue_bottom_left,
  input  wire logic [7:0]        in_red_bottom_right,
  input  wire logic [7:0]        in_green_bottom_right,
  input  wire logic [7:0]        in_blue_bottom_right,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [7:0]      out_luma_top_left,
  output logic signed [7:0]      out_luma_top_right,
  output logic signed [7:0]      out_luma_bottom_left,
  output logic signed [7:0]      out_luma_bottom_right,
  output logic signed [7:0]      out_blue_difference,
  output logic signed [7:0]      out_red_difference
);

  rqy_pkg::rqy_pipe_ctl_t ctl;

  logic [7:0] luma [4];
  logic [7:0] cb   [4];
  logic [7:0] cr   [4];
  logic [7:0] red  [4];
  logic [7:0] grn  [4];
  logic [7:0] blu  [4];

  logic [9:0] cb_sum, cr_sum;

  logic [7:0] luma_tl_r, luma_tr_r, luma_bl_r, luma_br_r, cb_r, cr_r;

  rqy_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  assign red[0] = in_red_top_left;
  assign grn[0] = in_green_top_left;
  assign blu[0] = in_blue_top_left;
  assign red[1] = in_red_top_right;
  assign grn[1] = in_green_top_right;
  assign blu[1] = in_blue_top_right;
  assign red[2] = in_red_bottom_left;
  assign grn[2] = in_green_bottom_left;
  assign blu[2] = in_blue_bottom_left;
  assign red[3] = in_red_bottom_right;
  assign grn[3] = in_green_bottom_right;
  assign blu[3] = in_blue_bottom_right;

  // One datapath lane per pixel of the quad
  for (genvar p = 0; p < 4; p++) begin : g_pix
    rqy_pixel u_pix (
      .clk   (clk),
      .ctl   (ctl),
      .red   (red[p]),
      .green (grn[p]),
      .blue  (blu[p]),
      .luma  (luma[p]),
      .cb    (cb[p]),
      .cr    (cr[p])
    );
  end

  // Average chroma over the quad
  assign cb_sum = {2'b00, cb[0]} + {2'b00, cb[1]} + {2'b00, cb[2]} + {2'b00, cb[3]};
  assign cr_sum = {2'b00, cr[0]} + {2'b00, cr[1]} + {2'b00, cr[2]} + {2'b00, cr[3]};

  // Output stage: remove the offset, wrap to 8 bits
  always_ff @(posedge clk) begin
    if (ctl.load[rqy_pkg::STG_OUT]) begin
      luma_tl_r <= luma[0] - rqy_pkg::OUT_OFFSET;
      luma_tr_r <= luma[1] - rqy_pkg::OUT_OFFSET;
      luma_bl_r <= luma[2] - rqy_pkg::OUT_OFFSET;
      luma_br_r <= luma[3] - rqy_pkg::OUT_OFFSET;
      cb_r      <= cb_sum[9:2] - rqy_pkg::OUT_OFFSET;
      cr_r      <= cr_sum[9:2] - rqy_pkg::OUT_OFFSET;
    end
  end

  assign out_luma_top_left     = $signed(luma_tl_r);
  assign out_luma_top_right    = $signed(luma_tr_r);
  assign out_luma_bottom_left  = $signed(luma_bl_r);
  assign out_luma_bottom_right = $signed(luma_br_r);
  assign out_blue_difference   = $signed(cb_r);
  assign out_red_difference    = $signed(cr_r);

endmodule

`default_nettype wire

// ===== hw/rtl/rqy_checker.sv =====
// Port-level checks for rgb_quad_to_ycbcr420_unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module rqy_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [7:0] out_luma_top_left,
  input wire logic signed [7:0] out_luma_top_right,
  input wire logic signed [7:0] out_luma_bottom_left,
  input wire logic signed [7:0] out_luma_bottom_right,
  input wire logic signed [7:0] out_blue_difference,
  input wire logic signed [7:0] out_red_difference
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A draining output never blocks the input side
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while output side is ready");

  // A beat taken with no backpressure shows up once it has passed every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready |=> out_valid)
    else $error("output beat missing at expected latency");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable(out_luma_top_left) && $stable(out_luma_top_right)
      && $stable(out_luma_bottom_left) && $stable(out_luma_bottom_right)
      && $stable(out_blue_difference) && $stable(out_red_difference))
    else $error("stalled output beat changed or dropped");

endmodule

bind rgb_quad_to_ycbcr420_unit rqy_checker u_rqy_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_luma_top_left     (out_luma_top_left),
  .out_luma_top_right    (out_luma_top_right),
  .out_luma_bottom_left  (out_luma_bottom_left),
  .out_luma_bottom_right (out_luma_bottom_right),
  .out_blue_difference   (out_blue_difference),
  .out_red_difference    (out_red_difference)
);

`default_nettype wire

// ===== dv/tb_rgb_quad_to_ycbcr420_unit.sv =====
// Testbench for rgb_quad_to_ycbcr420_unit: drives 2x2 RGB quads and checks each
// YCbCr 4:2:0 output beat against a fixed-point predictor kept in this file.
// Depends on the unit and its package rqy_pkg, compiled alongside.
`timescale 1ns / 1ps

module tb_rgb_quad_to_ycbcr420_unit;

  // Fixed-point conversion constants (12-bit fraction)
  localparam int LUMA_R_WEIGHT = 1224;
  localparam int LUMA_G_WEIGHT = 2404;
  localparam int LUMA_B_WEIGHT = 466;
  localparam int CB_WEIGHT     = 2314;
  localparam int CR_WEIGHT     = 2920;
  localparam int HALF_STEP     = 8;
  localparam int CHROMA_MID    = 127;
  localparam int OUT_BIAS      = 128;

  localparam int MAX_REPORTS   = 10;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_QUADS  = 580;
  localparam int STREAM_QUADS  = 100;

  // Pixel positions within a quad; luma field k belongs to pixel k
  localparam int PIX_TL = 0;
  localparam int PIX_TR = 1;
  localparam int PIX_BL = 2;
  localparam int PIX_BR = 3;

  typedef enum int {
    FLD_LUMA_TL, FLD_LUMA_TR, FLD_LUMA_BL, FLD_LUMA_BR, FLD_BLUE_DIFF, FLD_RED_DIFF
  } ycc_field_t;

  typedef enum int {QUAD_ANY, QUAD_SMOOTH, QUAD_SATURATED, QUAD_GRAY, QUAD_VIVID} quad_kind_t;
  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  typedef rgb_pixel_t [3:0] rgb_quad_t;
  typedef logic [5:0][7:0] ycc_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red_top_left = '0;
  logic [7:0] in_green_top_left = '0;
  logic [7:0] in_blue_top_left = '0;
  logic [7:0] in_red_top_right = '0;
  logic [7:0] in_green_top_right = '0;
  logic [7:0] in_blue_top_right = '0;
  logic [7:0] in_red_bottom_left = '0;
  logic [7:0] in_green_bottom_left = '0;
  logic [7:0] in_blue_bottom_left = '0;
  logic [7:0] in_red_bottom_right = '0;
  logic [7:0] in_green_bottom_right = '0;
  logic [7:0] in_blue_bottom_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [7:0] out_luma_top_left;
  logic signed [7:0] out_luma_top_right;
  logic signed [7:0] out_luma_bottom_left;
  logic signed [7:0] out_luma_bottom_right;
  logic signed [7:0] out_blue_difference;
  logic signed [7:0] out_red_difference;

  ycc_beat_t pending_ycc[$];
  int quads_taken = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int directed_quads = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit full_rate = 1'b0;

  rgb_quad_to_ycbcr420_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_red_top_left      (in_red_top_left),
    .in_green_top_left    (in_green_top_left),
    .in_blue_top_left     (in_blue_top_left),
    .in_red_top_right     (in_red_top_right),
    .in_green_top_right   (in_green_top_right),
    .in_blue_top_right    (in_blue_top_right),
    .in_red_bottom_left   (in_red_bottom_left),
    .in_green_bottom_left (in_green_bottom_left),
    .in_blue_bottom_left  (in_blue_bottom_left),
    .in_red_bottom_right  (in_red_bottom_right),
    .in_green_bottom_right(in_green_bottom_right),
    .in_blue_bottom_right (in_blue_bottom_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_luma_top_left    (out_luma_top_left),
    .out_luma_top_right   (out_luma_top_right),
    .out_luma_bottom_left (out_luma_bottom_left),
    .out_luma_bottom_right(out_luma_bottom_right),
    .out_blue_difference  (out_blue_difference),
    .out_red_difference   (out_red_difference)
  );

  always #10 clk = ~clk;

  // Scale by 2/3 with truncation toward zero, then clamp to a byte
  function automatic int scale_two_thirds(input int value);
    int scaled;
    scaled = (value * 2) / 3;
    if (scaled < 0) return 0;
    if (scaled > 255) return 255;
    return scaled;
  endfunction

  // Expected output beat for one quad
  function automatic ycc_beat_t predict_ycc420(input rgb_quad_t quad);
    ycc_beat_t beat;
    int r12, g12, b12, y12, u12, v12;
    int cb_sum, cr_sum;
    cb_sum = 0;
    cr_sum = 0;
    for (int k = 0; k < 4; k++) begin
      r12 = (int'(quad[k].red) << 4) + HALF_STEP;
      g12 = (int'(quad[k].green) << 4) + HALF_STEP;
      b12 = (int'(quad[k].blue) << 4) + HALF_STEP;
      y12 = (LUMA_R_WEIGHT * r12 + LUMA_G_WEIGHT * g12 + LUMA_B_WEIGHT * b12) >>> 12;
      // floor shifts on signed differences
      u12 = ((b12 - y12) * CB_WEIGHT) >>> 12;
      v12 = ((r12 - y12) * CR_WEIGHT) >>> 12;
      beat[k] = 8'(scale_two_thirds(y12 >>> 4) - OUT_BIAS);
      cb_sum += scale_two_thirds((u12 >>> 4) + CHROMA_MID);
      cr_sum += scale_two_thirds((v12 >>> 4) + CHROMA_MID);
    end
    beat[FLD_BLUE_DIFF] = 8'((cb_sum >>> 2) - OUT_BIAS);
    beat[FLD_RED_DIFF]  = 8'((cr_sum >>> 2) - OUT_BIAS);
    return beat;
  endfunction

  function automatic rgb_quad_t uniform_quad(input logic [7:0] r, g, b);
    rgb_quad_t quad;
    for (int k = 0; k < 4; k++) quad[k] = {r, g, b};
    return quad;
  endfunction

  // Random quad of the given flavor
  function automatic rgb_quad_t random_quad(input quad_kind_t kind);
    rgb_quad_t quad;
    int base[3];
    int chan;
    logic [2:0] mask;
    logic [7:0] level;
    for (int c = 0; c < 3; c++) base[c] = $urandom_range(0, 255);
    for (int k = 0; k < 4; k++) begin
      case (kind)
        QUAD_SMOOTH: begin
          // neighbors close to a common color
          for (int c = 0; c < 3; c++) begin
            chan = base[c] + $urandom_range(0, 32) - 16;
            if (chan < 0) chan = 0;
            if (chan > 255) chan = 255;
            quad[k][23 - 8*c -: 8] = 8'(chan);
          end
        end
        QUAD_SATURATED: begin
          for (int c = 0; c < 3; c++) begin
            case ($urandom_range(0, 5))
              0: level = 8'd1;
              1: level = 8'd254;
              2, 3: level = 8'd0;
              default: level = 8'd255;
            endcase
            quad[k][23 - 8*c -: 8] = level;
          end
        end
        QUAD_GRAY: begin
          level = 8'($urandom_range(0, 255));
          quad[k] = {level, level, level};
        end
        QUAD_VIVID: begin
          // near-saturated hues push chroma to both ends of its range
          mask = 3'($urandom_range(0, 7));
          for (int c = 0; c < 3; c++)
            quad[k][23 - 8*c -: 8] = mask[c] ? 8'($urandom_range(224, 255))
                                             : 8'($urandom_range(0, 31));
        end
        default: quad[k] = 24'($urandom);
      endcase
    end
    return quad;
  endfunction

  // Idle per burst plan, then present one quad and hold it until taken
  task automatic send_quad(input rgb_quad_t quad);
    int gap;
    if (!full_rate) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: gap = 0;
          7: gap = $urandom_range(10, 24);
          default: gap = $urandom_range(1, 5);
        endcase
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 24);
      end
    end
    @(negedge clk);
    in_red_top_left       <= quad[PIX_TL].red;
    in_green_top_left     <= quad[PIX_TL].green;
    in_blue_top_left      <= quad[PIX_TL].blue;
    in_red_top_right      <= quad[PIX_TR].red;
    in_green_top_right    <= quad[PIX_TR].green;
    in_blue_top_right     <= quad[PIX_TR].blue;
    in_red_bottom_left    <= quad[PIX_BL].red;
    in_green_bottom_left  <= quad[PIX_BL].green;
    in_blue_bottom_left   <= quad[PIX_BL].blue;
    in_red_bottom_right   <= quad[PIX_BR].red;
    in_green_bottom_right <= quad[PIX_BR].green;
    in_blue_bottom_right  <= quad[PIX_BR].blue;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver stall pattern: switch to a random mode when rx_mode_left runs out
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int rx_phase = 0;
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    if (full_rate) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ready <= ((rx_phase % 7) < 4);
        RX_CHOKED:   out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // Predict on every accepted quad, compare every accepted output beat
  always @(posedge clk) begin
    rgb_quad_t seen;
    ycc_beat_t got;
    ycc_beat_t want;
    ycc_field_t fld;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got[FLD_LUMA_TL]   = out_luma_top_left;
        got[FLD_LUMA_TR]   = out_luma_top_right;
        got[FLD_LUMA_BL]   = out_luma_bottom_left;
        got[FLD_LUMA_BR]   = out_luma_bottom_right;
        got[FLD_BLUE_DIFF] = out_blue_difference;
        got[FLD_RED_DIFF]  = out_red_difference;
        if (pending_ycc.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: output beat with no quad outstanding, luma_tl=%0d",
                     $signed(got[FLD_LUMA_TL]));
        end else begin
          want = pending_ycc.pop_front();
          for (int f = 0; f < 6; f++) begin
            fld = ycc_field_t'(f);
            if (got[f] !== want[f]) begin
              mismatches++;
              if (mismatches <= MAX_REPORTS)
                $display("ERROR: beat %0d %s expected %0d got %0d", beats_checked,
                         fld.name(), $signed(want[f]), $signed(got[f]));
            end
          end
        end
        beats_checked++;
      end
      if (in_valid && in_ready) begin
        seen[PIX_TL] = {in_red_top_left, in_green_top_left, in_blue_top_left};
        seen[PIX_TR] = {in_red_top_right, in_green_top_right, in_blue_top_right};
        seen[PIX_BL] = {in_red_bottom_left, in_green_bottom_left, in_blue_bottom_left};
        seen[PIX_BR] = {in_red_bottom_right, in_green_bottom_right, in_blue_bottom_right};
        pending_ycc.push_back(predict_ycc420(seen));
        quads_taken++;
      end
    end
    // Watchdog: end the run when no beat moves for too long
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Black, white, red, blue, secondaries and mixed-hue quads; yellow and
  // cyan drive chroma below zero before the clamp
  task automatic test_corner_quads();
    rgb_quad_t quad;
    send_quad(uniform_quad(8'd0, 8'd0, 8'd0));
    send_quad(uniform_quad(8'd255, 8'd255, 8'd255));
    send_quad(uniform_quad(8'd255, 8'd255, 8'd0));
    send_quad(uniform_quad(8'd0, 8'd255, 8'd255));
    send_quad(uniform_quad(8'd255, 8'd0, 8'd255));
    send_quad(uniform_quad(8'd255, 8'd0, 8'd0));
    send_quad(uniform_quad(8'd0, 8'd0, 8'd255));
    quad[PIX_TL] = {8'd255, 8'd0, 8'd0};
    quad[PIX_TR] = {8'd0, 8'd255, 8'd0};
    quad[PIX_BL] = {8'd0, 8'd0, 8'd255};
    quad[PIX_BR] = {8'd255, 8'd255, 8'd255};
    send_quad(quad);
    quad[PIX_TL] = {8'd0, 8'd0, 8'd0};
    quad[PIX_TR] = {8'd255, 8'd255, 8'd255};
    quad[PIX_BL] = {8'd255, 8'd255, 8'd255};
    quad[PIX_BR] = {8'd0, 8'd0, 8'd0};
    send_quad(quad);
    quad[PIX_TL] = {8'd255, 8'd255, 8'd0};
    quad[PIX_TR] = {8'd0, 8'd255, 8'd255};
    quad[PIX_BL] = {8'd0, 8'd0, 8'd0};
    quad[PIX_BR] = {8'd255, 8'd255, 8'd255};
    send_quad(quad);
    directed_quads += 10;
  endtask

  // Walk a one through every bit of every channel, then both checker bytes
  task automatic test_walking_bits();
    for (int b = 0; b < 8; b++) send_quad(uniform_quad(8'(1 << b), 8'(1 << b), 8'(1 << b)));
    send_quad(uniform_quad(8'h55, 8'hAA, 8'h55));
    send_quad(uniform_quad(8'hAA, 8'h55, 8'hAA));
    directed_quads += 10;
  endtask

  // Mixed random quads under bursty sender and stalling receiver
  task automatic test_random_quads(input int count);
    quad_kind_t kind;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: kind = QUAD_ANY;
        3, 4:    kind = QUAD_SMOOTH;
        5:       kind = QUAD_SATURATED;
        6:       kind = QUAD_GRAY;
        default: kind = QUAD_VIVID;
      endcase
      send_quad(random_quad(kind));
    end
  endtask

  // Back-to-back quads with the receiver always ready
  task automatic test_full_rate_stream(input int count);
    full_rate = 1'b1;
    for (int n = 0; n < count; n++) send_quad(random_quad(quad_kind_t'($urandom_range(0, 4))));
    full_rate = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_quads();
    test_walking_bits();
    test_random_quads(RANDOM_QUADS);
    test_full_rate_stream(STREAM_QUADS);

    // Drop valid and drain; the watchdog bounds the wait
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ycc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d RGB quads (%0d directed) through bursty, stalled and full-rate traffic;",
             quads_taken, directed_quads);
    $display("checked %0d output beats, %0d field mismatches.", beats_checked, mismatches);
    if (mismatches == 0 && pending_ycc.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rqy_pkg.sv
hw/rtl/rqy_ctrl.sv
hw/rtl/rqy_pixel.sv
hw/rtl/rgb_quad_to_ycbcr420_unit.sv
hw/rtl/rqy_checker.sv
dv/tb_rgb_quad_to_ycbcr420_unit.sv
